/* rtl/deq_pkg.sv */
package deq_pkg;

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

    // pointer update commands from the sequencer
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } ptr_cmd_t;

    // occupancy flags back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } ptr_flags_t;

endpackage

/* rtl/double_ended_queue_unit.sv */
// Bounded double-ended queue held in a single circular buffer memory.
// Input channel (s_valid/s_ready): s_req_type picks push front/back, pop
// front/back or peek front/back; s_push_value is the item stored by a push.
// Result channel (m_valid/m_ready): one result item per request with the
// value popped or peeked, the element count after the request and a status
// (ok, empty on pop or peek, full on push). Codes 6 and 7 change nothing.
// Timing: pushes, errors and unused codes load the result register in the
// cycle after acceptance; a pop or peek first passes through the registered
// memory read (ST_READ) before its result register is loaded.
// Throughput: one request per cycle for pushes while results are taken; a pop
// or peek blocks new requests until its memory read has finished.
// A new request is taken while the previous result is being taken in the
// same cycle; if the receiver stalls, the result holds and s_ready stays low.
// Reset (aresetn low, synchronous) empties the queue and the result register;
// memory contents are not cleared, since only occupied entries are ever read.
module double_ended_queue_unit #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_req_type,
    input  logic [DATA_WIDTH-1:0]      s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [DATA_WIDTH-1:0]      m_read_value,
    output logic [$clog2(DEPTH+1)-1:0] m_element_count,
    output logic [1:0]                 m_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::state_t     state_reg, state_next;
    deq_pkg::ptr_cmd_t   cmd;
    deq_pkg::ptr_flags_t flags;

    logic [AW-1:0]         front_addr, back_addr, push_front_addr, push_back_addr;
    logic [AW-1:0]         waddr, raddr;
    logic [CW-1:0]         count, count_next;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  we, re, accept;

    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_read_value_reg, m_read_value_next;
    logic [CW-1:0]         m_element_count_reg, m_element_count_next;
    logic [1:0]            m_status_reg, m_status_next;

    deq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .front_addr     (front_addr),
        .back_addr      (back_addr),
        .push_front_addr(push_front_addr),
        .push_back_addr (push_back_addr),
        .count          (count),
        .count_next     (count_next),
        .flags          (flags)
    );

    deq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(s_push_value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // take a request only while idle and the result slot frees up
    assign s_ready = (state_reg == deq_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // request decode, memory access and result loading
    always_comb begin
        state_next           = state_reg;
        cmd                  = '0;
        we                   = 1'b0;
        re                   = 1'b0;
        waddr                = push_back_addr;
        raddr                = front_addr;
        m_valid_next         = m_valid_reg && !m_ready;
        m_read_value_next    = m_read_value_reg;
        m_element_count_next = m_element_count_reg;
        m_status_next        = m_status_reg;
        unique case (state_reg)
            deq_pkg::ST_IDLE: begin
                if (accept) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = '0;
                    m_status_next     = deq_pkg::STATUS_OK;
                    unique case (s_req_type) inside
                        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
                            if (flags.full) begin
                                m_status_next = deq_pkg::STATUS_FULL;
                            end else begin
                                we = 1'b1;
                                if (s_req_type == deq_pkg::REQ_PUSH_FRONT) begin
                                    cmd.push_front = 1'b1;
                                    waddr          = push_front_addr;
                                end else begin
                                    cmd.push_back = 1'b1;
                                end
                            end
                        end
                        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK,
                        deq_pkg::REQ_PEEK_FRONT, deq_pkg::REQ_PEEK_BACK: begin
                            if (flags.empty) begin
                                m_status_next = deq_pkg::STATUS_EMPTY;
                            end else begin
                                // result waits for the memory read
                                re           = 1'b1;
                                m_valid_next = 1'b0;
                                state_next   = deq_pkg::ST_READ;
                                if (s_req_type == deq_pkg::REQ_POP_BACK ||
                                    s_req_type == deq_pkg::REQ_PEEK_BACK) begin
                                    raddr = back_addr;
                                end
                                cmd.pop_front = (s_req_type == deq_pkg::REQ_POP_FRONT);
                                cmd.pop_back  = (s_req_type == deq_pkg::REQ_POP_BACK);
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_element_count_next = count_next;
                end
            end
            deq_pkg::ST_READ: begin
                // pointers already hold the post-request state
                m_valid_next         = 1'b1;
                m_read_value_next    = rdata;
                m_element_count_next = count;
                m_status_next        = deq_pkg::STATUS_OK;
                state_next           = deq_pkg::ST_IDLE;
            end
            default: begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_read_value_reg    <= m_read_value_next;
        m_element_count_reg <= m_element_count_next;
        m_status_reg        <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_element_count = m_element_count_reg;
    assign m_status        = m_status_reg;

    // result slot is empty while a memory read is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == deq_pkg::ST_READ) |-> !m_valid_reg)
        else $error("result slot busy during memory read");

    // an accepted non-empty pop or peek goes to the read state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && re) |=> (state_reg == deq_pkg::ST_READ))
        else $error("read request did not enter read state");

    // failed requests (full or empty status) carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != deq_pkg::STATUS_OK) |-> (m_read_value == '0))
        else $error("error result with nonzero value");

    // count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_element_count <= CW'(DEPTH)))
        else $error("element count above capacity");

endmodule

/* rtl/deq_ram.sv */
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/deq_ptr.sv */
module deq_ptr #(
    parameter int DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  deq_pkg::ptr_cmd_t          cmd,
    output logic [$clog2(DEPTH)-1:0]   front_addr,
    output logic [$clog2(DEPTH)-1:0]   back_addr,
    output logic [$clog2(DEPTH)-1:0]   push_front_addr,
    output logic [$clog2(DEPTH)-1:0]   push_back_addr,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [$clog2(DEPTH+1)-1:0] count_next,
    output deq_pkg::ptr_flags_t        flags
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] tail_sum, back_sum, tail_wrap, back_wrap;

    // end positions, wrapped by one compare and subtract
    always_comb begin
        tail_sum  = SW'(front_reg) + SW'(count_reg);
        back_sum  = tail_sum - SW'(1);
        tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
        back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    end

    assign front_addr      = front_reg;
    assign back_addr       = back_wrap[AW-1:0];
    assign push_back_addr  = tail_wrap[AW-1:0];
    assign push_front_addr = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CW'(DEPTH));
    assign count       = count_reg;

    // next front and count
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push_front) begin
            front_next = push_front_addr;
            count_next = count_reg + CW'(1);
        end else if (cmd.push_back) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop_front) begin
            front_next = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end else if (cmd.pop_back) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule
